// ----- hdl/lsvr_pkg.sv -----
// ----------------------------------------------------------------------------
// lsvr_pkg
// Shared types and constants of the looping sample voice resampler: payload
// words, configuration register indexes, item modes and sequencer states.
// ----------------------------------------------------------------------------
package lsvr_pkg;

  // Sample store geometry and phase format.
  localparam int unsigned SAMPLE_DEPTH  = 65536;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned ADDR_W        = $clog2(SAMPLE_DEPTH);

  // Fixed field widths.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned INC_W     = 40;
  localparam int unsigned FRAME_W   = 17;
  localparam int unsigned EFF_W     = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = INC_W;

  // Divider step counter.
  localparam int unsigned CNT_W = $clog2(INC_W);

  // Width that holds phase + step and the end and loop positions in phase units.
  localparam int unsigned WIDE_W = ((INC_W > FRAME_W + FRACTION_BITS) ?
                                    INC_W : (FRAME_W + FRACTION_BITS)) + 2;

  // Interpolation product: 17-bit signed difference times unsigned fraction.
  localparam int unsigned PROD_W = SAMPLE_W + 1 + FRACTION_BITS + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INCREMENT = 3'd0,
    CFG_END_FRAME = 3'd1,
    CFG_LOOP_LEN  = 3'd2,
    CFG_LOOP_EN   = 3'd3,
    CFG_LINEAR    = 3'd4
  } cfg_index_e;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_START  = 2'd1,
    MODE_RENDER = 2'd2
  } mode_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADD,
    ST_DONE
  } state_e;

  // Input word.
  typedef struct packed {
    logic [1:0]                 mode;
    logic [15:0]                address;
    logic signed [SAMPLE_W-1:0] sample_word;
    logic [15:0]                period;
    logic signed [15:0]         period_offset;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] frame_value;
    logic                       playing;
  } out_item_t;

endpackage

// ----- hdl/looping_sample_voice_resampler_top.sv -----
// ----------------------------------------------------------------------------
// looping_sample_voice_resampler_top
// Tracker voice: plays a stored sample at a pitch set by a note period, with
// optional linear interpolation and a repeating loop section.
// ----------------------------------------------------------------------------
// A write or start word, and a render word that gives silence (period 0, or
// the voice stopped), are handled without leaving the idle state. A render
// word that plays stalls the input until it is done: a restoring divider
// forms the phase step one quotient bit per cycle over the 40 bits of
// increment_per_period, the ST_ADD state adds the step, and the ST_DONE state
// applies the end and loop rules and loads the result. The two store reads
// and the interpolation multiply run during the divide. A result that is not
// taken holds off the next input word. The sample store has no reset; reading
// an entry that was never written returns whatever it holds.
// ----------------------------------------------------------------------------
module looping_sample_voice_resampler_top
  import lsvr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // Step counter values at which the store reads and the multiply happen.
  localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(INC_W - 1);
  localparam logic [CNT_W-1:0] CNT_S0    = CNT_W'(INC_W - 2);
  localparam logic [CNT_W-1:0] CNT_S1    = CNT_W'(INC_W - 3);
  localparam logic [CNT_W-1:0] CNT_MUL   = CNT_W'(INC_W - 4);

  // Configuration registers.
  logic [INC_W-1:0]   incr_q;
  logic [FRAME_W-1:0] end_frame_q;
  logic [FRAME_W-1:0] loop_len_q;
  logic               loop_en_q;
  logic               linear_q;

  // Voice state.
  logic [PHASE_W-1:0] phase_q;
  logic               stopped_q;

  // Sequencer and datapath.
  state_e                     state_q, state_d;
  logic [CNT_W-1:0]           cnt_q;
  logic [EFF_W-1:0]           eff_q;
  logic [EFF_W-1:0]           rem_q;
  logic [INC_W-1:0]           quo_q;
  logic signed [SAMPLE_W-1:0] s0_q;
  logic signed [SAMPLE_W-1:0] s1_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [WIDE_W-1:0]          next_q;
  logic                       out_valid_q;
  out_item_t                  out_q;

  // Control strobes.
  logic in_fire;
  logic out_busy;
  logic start_div;
  logic silent_load;
  logic done_load;

  // Store access.
  logic [ADDR_W-1:0]   idx;
  logic [ADDR_W-1:0]   raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic                store_we;
  logic [PHASE_W-1:0]  idx_full;

  // Effective period.
  logic signed [EFF_W:0] eff_sum;
  logic [EFF_W-1:0]      eff_floor;

  // Divider step.
  logic [EFF_W:0]   trial;
  logic             quo_bit;
  logic [EFF_W-1:0] rem_next;

  // Interpolation.
  logic signed [SAMPLE_W:0]        diff;
  logic signed [FRACTION_BITS:0]   frac_s;
  logic signed [PROD_W-1:0]        prod_d;
  logic signed [PROD_W-1:0]        part_full;
  logic signed [SAMPLE_W+1:0]      val_sum;
  logic signed [SAMPLE_W-1:0]      frame_val;

  // Phase advance.
  logic [WIDE_W-1:0] end_fixed;
  logic [WIDE_W-1:0] back;
  logic              past_end;
  logic              stop_now;
  logic [WIDE_W-1:0] wrapped;
  logic [PHASE_W-1:0] phase_next;

  // Handshakes.
  assign out_busy    = out_valid_q && out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || out_busy;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incr_q      <= '0;
      end_frame_q <= '0;
      loop_len_q  <= '0;
      loop_en_q   <= 1'b0;
      linear_q    <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_INCREMENT: incr_q      <= cfg_data_i[INC_W-1:0];
        CFG_END_FRAME: end_frame_q <= cfg_data_i[FRAME_W-1:0];
        CFG_LOOP_LEN:  loop_len_q  <= cfg_data_i[FRAME_W-1:0];
        CFG_LOOP_EN:   loop_en_q   <= cfg_data_i[0];
        CFG_LINEAR:    linear_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective period, floored at one.
  assign eff_sum = $signed({{(EFF_W + 1 - 16){1'b0}}, in_data_i.period}) +
                   $signed({{(EFF_W + 1 - 16){in_data_i.period_offset[15]}},
                            in_data_i.period_offset});
  assign eff_floor = (eff_sum[EFF_W] || (eff_sum == '0)) ? EFF_W'(1) : eff_sum[EFF_W-1:0];

  // Sequencer: next state and strobes.
  always_comb begin
    state_d     = state_q;
    start_div   = 1'b0;
    silent_load = 1'b0;
    done_load   = 1'b0;
    store_we    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data_i.mode)
            MODE_WRITE: store_we = 1'b1;
            MODE_RENDER: begin
              if ((in_data_i.period == '0) || stopped_q) begin
                silent_load = 1'b1;
              end else begin
                start_div = 1'b1;
                state_d   = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy) begin
          done_load = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sample store: frame index and its successor, both wrapping.
  assign idx_full = phase_q >> FRACTION_BITS;
  assign idx      = idx_full[ADDR_W-1:0];
  assign raddr    = (state_q == ST_DIV && cnt_q == CNT_S0) ? idx + ADDR_W'(1) : idx;

  lsvr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (in_data_i.address[ADDR_W-1:0]),
    .wdata_i (in_data_i.sample_word),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // One restoring divide step: shift in the next dividend bit, subtract if it fits.
  assign trial    = {rem_q, quo_q[INC_W-1]};
  assign quo_bit  = (trial >= {1'b0, eff_q});
  assign rem_next = quo_bit ? EFF_W'(trial - {1'b0, eff_q}) : trial[EFF_W-1:0];

  // Interpolation product of the sample difference and the phase fraction.
  assign diff   = $signed({s1_q[SAMPLE_W-1], s1_q}) - $signed({s0_q[SAMPLE_W-1], s0_q});
  assign frac_s = $signed({1'b0, phase_q[FRACTION_BITS-1:0]});
  assign prod_d = diff * frac_s;

  // Divider, store reads and multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_div) begin
      cnt_q <= CNT_FIRST;
    end else if (state_q == ST_DIV) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_div) begin
      eff_q <= eff_floor;
      rem_q <= '0;
      quo_q <= incr_q;
    end else if (state_q == ST_DIV) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[INC_W-2:0], quo_bit};
      if (cnt_q == CNT_S0) begin
        s0_q <= rdata;
      end
      if (cnt_q == CNT_S1) begin
        s1_q <= rdata;
      end
      if (cnt_q == CNT_MUL) begin
        prod_q <= prod_d;
      end
    end
    if (state_q == ST_ADD) begin
      next_q <= WIDE_W'(phase_q) + WIDE_W'(quo_q);
    end
  end

  // Frame value: floor of the scaled product added to the lower frame, or the lower frame alone when linear is off.
  assign part_full = prod_q >>> FRACTION_BITS;
  assign val_sum   = $signed({{2{s0_q[SAMPLE_W-1]}}, s0_q}) + part_full[SAMPLE_W+1:0];
  assign frame_val = linear_q ? val_sum[SAMPLE_W-1:0] : s0_q;

  // End and loop rules on the advanced phase.
  assign end_fixed  = WIDE_W'(end_frame_q) << FRACTION_BITS;
  assign back       = WIDE_W'(loop_len_q) << FRACTION_BITS;
  assign past_end   = (next_q >= end_fixed);
  assign stop_now   = past_end && (!loop_en_q || (loop_len_q == '0));
  assign wrapped    = !past_end ? next_q : ((back > next_q) ? '0 : next_q - back);
  assign phase_next = (|wrapped[WIDE_W-1:PHASE_W]) ? '1 : wrapped[PHASE_W-1:0];

  // Voice state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      stopped_q <= 1'b1;
    end else if (in_fire && (in_data_i.mode == MODE_START)) begin
      phase_q   <= PHASE_W'(in_data_i.address) << FRACTION_BITS;
      stopped_q <= 1'b0;
    end else if (done_load) begin
      if (stop_now) begin
        stopped_q <= 1'b1;
      end else begin
        phase_q <= phase_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (silent_load || done_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (silent_load) begin
      out_q.frame_value <= '0;
      out_q.playing     <= 1'b0;
    end else if (done_load) begin
      out_q.frame_value <= frame_val;
      out_q.playing     <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // The divider remainder always stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < eff_q))
    else $error("divider remainder not below divisor");

  // The floored period never reaches the divider as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (eff_q != '0))
    else $error("zero divisor in divide");

  // A new result comes only from a render word or a finished render.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i)) |->
      $past((state_q == ST_DONE) ||
            (in_fire && (in_data_i.mode == MODE_RENDER))))
    else $error("result word without a render");
`endif

endmodule

// ----- hdl/lsvr_ram.sv -----
// ----------------------------------------------------------------------------
// lsvr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsvr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
